// ----- sv/vertex_component_to_float_defines.svh -----
// ----------------------------------------------------------------------------
// vertex_component_to_float_defines
// assertion macros used by the converter rtl
// ----------------------------------------------------------------------------
`ifndef VERTEX_COMPONENT_TO_FLOAT_DEFINES_SVH
`define VERTEX_COMPONENT_TO_FLOAT_DEFINES_SVH
`ifndef ASSERT_OFF
// implication checked on every clock edge outside reset
`define VCF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("vcf assertion failed");
// condition in the cycle after the antecedent
`define VCF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("vcf assertion failed");
`else
`define VCF_ASSERT_IMP(lbl, ante, cons)
`define VCF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- sv/vcf_pkg.sv -----
// ----------------------------------------------------------------------------
// vcf_pkg
// shared types, codes and helpers of the vertex component converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package vcf_pkg;

	typedef enum logic [2:0] {
		CT_S8    = 3'd0,
		CT_U8    = 3'd1,
		CT_S16   = 3'd2,
		CT_U16   = 3'd3,
		CT_U32   = 3'd4,
		CT_FLOAT = 3'd5
	} ctype_t;

	localparam logic CFG_IDX_TYPE = 1'b0;
	localparam logic CFG_IDX_NORM = 1'b1;
	localparam logic [2:0] CTYPE_RESET = 3'd5;

	// biased exponent of string bit 47
	localparam logic [7:0] EXP_INT  = 8'd158;
	localparam logic [7:0] EXP_FRAC = 8'd126;
	localparam logic [7:0] EXP_ONE  = 8'd127;

	typedef enum logic [1:0] {
		K_ZERO = 2'd0,
		K_PASS = 2'd1,
		K_ONE  = 2'd2,
		K_NORM = 2'd3
	} kind_t;

	// operand handed from decode to normalize/round
	typedef struct packed {
		kind_t        kind;
		logic         sign;
		logic [47:0]  str;
		logic [7:0]   exp_base;
		logic         force_sticky;
		logic [31:0]  raw;
	} prep_t;

	// leading zero count of a nonzero 32 bit word
	function automatic logic [4:0] lzc32(input logic [31:0] v);
		logic [4:0] n;
		n = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) n = 5'(31 - i);
		end
		return n;
	endfunction

endpackage

// ----- sv/vcf_if.sv -----
// ----------------------------------------------------------------------------
// vcf stream interfaces
// valid/ready channels for raw components and float results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface vcf_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] raw_bytes;
	modport source (output valid, output raw_bytes, input ready);
	modport sink (input valid, input raw_bytes, output ready);
endinterface

interface vcf_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] float_bits;
	modport source (output valid, output float_bits, input ready);
	modport sink (input valid, input float_bits, output ready);
endinterface

// ----- sv/vcf_prep.sv -----
// ----------------------------------------------------------------------------
// vcf_prep
// selects operand bits per component type and builds the bit string
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module vcf_prep (
	input  logic [31:0]    raw,
	input  logic [2:0]     ctype,
	input  logic           norm,
	output vcf_pkg::prep_t prep
);
	logic [7:0]  b8;
	logic [15:0] b16;
	logic [7:0]  m8;
	logic [15:0] m16;
	logic [48:0] rep7;
	logic [59:0] rep15;

	assign b8    = raw[7:0];
	assign b16   = raw[15:0];
	assign m8    = b8[7] ? 8'(-b8) : b8;
	assign m16   = b16[15] ? 16'(-b16) : b16;
	// x/(2^w-1) below one is x repeated in w bit blocks
	assign rep7  = {7{m8[6:0]}};
	assign rep15 = {4{m16[14:0]}};

	always_comb begin
		prep.kind         = vcf_pkg::K_NORM;
		prep.sign         = 1'b0;
		prep.str          = 48'd0;
		prep.exp_base     = vcf_pkg::EXP_INT;
		prep.force_sticky = 1'b0;
		prep.raw          = raw;
		case (ctype)
			vcf_pkg::CT_S8: begin
				prep.sign = b8[7];
				if (norm) begin
					prep.str          = rep7[48:1];
					prep.exp_base     = vcf_pkg::EXP_FRAC;
					prep.force_sticky = 1'b1;
					if (m8 >= 8'd127) prep.kind = vcf_pkg::K_ONE;
				end else begin
					prep.str = {24'd0, m8, 16'd0};
				end
				if (m8 == 8'd0) prep.kind = vcf_pkg::K_ZERO;
			end
			vcf_pkg::CT_U8: begin
				if (norm) begin
					prep.str          = {6{b8}};
					prep.exp_base     = vcf_pkg::EXP_FRAC;
					prep.force_sticky = 1'b1;
					if (b8 == 8'hff) prep.kind = vcf_pkg::K_ONE;
				end else begin
					prep.str = {24'd0, b8, 16'd0};
				end
				if (b8 == 8'd0) prep.kind = vcf_pkg::K_ZERO;
			end
			vcf_pkg::CT_S16: begin
				prep.sign = b16[15];
				if (norm) begin
					prep.str          = rep15[59:12];
					prep.exp_base     = vcf_pkg::EXP_FRAC;
					prep.force_sticky = 1'b1;
					if (m16 >= 16'd32767) prep.kind = vcf_pkg::K_ONE;
				end else begin
					prep.str = {16'd0, m16, 16'd0};
				end
				if (m16 == 16'd0) prep.kind = vcf_pkg::K_ZERO;
			end
			vcf_pkg::CT_U16: begin
				if (norm) begin
					prep.str          = {3{b16}};
					prep.exp_base     = vcf_pkg::EXP_FRAC;
					prep.force_sticky = 1'b1;
					if (b16 == 16'hffff) prep.kind = vcf_pkg::K_ONE;
				end else begin
					prep.str = {16'd0, b16, 16'd0};
				end
				if (b16 == 16'd0) prep.kind = vcf_pkg::K_ZERO;
			end
			vcf_pkg::CT_U32: begin
				prep.str = {raw, 16'd0};
				if (raw == 32'd0) prep.kind = vcf_pkg::K_ZERO;
			end
			vcf_pkg::CT_FLOAT: prep.kind = vcf_pkg::K_PASS;
			default: prep.kind = vcf_pkg::K_ZERO;
		endcase
	end
endmodule

// ----- sv/vcf_round.sv -----
// ----------------------------------------------------------------------------
// vcf_round
// normalizes the bit string and rounds to single precision
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module vcf_round (
	input  vcf_pkg::prep_t prep,
	output logic [31:0]    float_bits
);
	logic [4:0]  lz;
	logic [47:0] sh;
	logic [22:0] mant;
	logic        guard;
	logic        sticky;
	logic        up;
	logic [23:0] sum;
	logic [7:0]  expo;

	assign lz     = vcf_pkg::lzc32(prep.str[47:16]);
	assign sh     = prep.str << lz;
	assign mant   = sh[46:24];
	assign guard  = sh[23];
	assign sticky = (|sh[22:0]) | prep.force_sticky;
	assign up     = guard & (sticky | mant[0]);
	assign sum    = {1'b0, mant} + {23'd0, up};
	assign expo   = prep.exp_base - {3'd0, lz} + {7'd0, sum[23]};

	always_comb begin
		case (prep.kind)
			vcf_pkg::K_PASS: float_bits = prep.raw;
			vcf_pkg::K_ONE:  float_bits = {prep.sign, vcf_pkg::EXP_ONE, 23'd0};
			vcf_pkg::K_NORM: float_bits = {prep.sign, expo, sum[22:0]};
			default:         float_bits = 32'd0;
		endcase
	end
endmodule

// ----- sv/vertex_component_to_float.sv -----
// path: input beat -> input register -> result register -> result beat
// throughput: one beat per cycle; a waiting result stalls stage 1 once it is full
// reset: arst_n clears both stage valids; type resets to float32, normalize off
// config: write only while the pipe is empty
`timescale 1ns / 1ps
`include "vertex_component_to_float_defines.svh"
// ----------------------------------------------------------------------------
// vertex_component_to_float
// converts one raw vertex attribute component to an ieee single float
// ----------------------------------------------------------------------------
module vertex_component_to_float (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [2:0]  cfg_wdata,
	vcf_in_if.sink      in_ch,
	vcf_out_if.source   out_ch
);
	// configuration registers
	logic [2:0]  ctype_q;
	logic        norm_q;

	// input register stage
	logic        valid_s1;
	logic [31:0] raw_s1;

	// result register stage
	logic        valid_s2;
	logic [31:0] float_bits_s2;

	logic           adv_s1;
	vcf_pkg::prep_t prep;
	logic [31:0]    float_bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctype_q <= vcf_pkg::CTYPE_RESET;
			norm_q  <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == vcf_pkg::CFG_IDX_TYPE) ctype_q <= cfg_wdata;
			if (cfg_index == vcf_pkg::CFG_IDX_NORM) norm_q  <= cfg_wdata[0];
		end
	end

	// stage 1 moves on whenever the result register is free or being drained
	assign adv_s1      = !valid_s2 || out_ch.ready;
	assign in_ch.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) raw_s1 <= in_ch.raw_bytes;
	end

	// decode the operand, then normalize and round
	vcf_prep u_prep (
		.raw   (raw_s1),
		.ctype (ctype_q),
		.norm  (norm_q),
		.prep  (prep)
	);

	vcf_round u_round (
		.prep       (prep),
		.float_bits (float_bits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) float_bits_s2 <= float_bits;
	end

	assign out_ch.valid      = valid_s2;
	assign out_ch.float_bits = float_bits_s2;

	// an empty result register never holds back the input side
	`VCF_ASSERT_IMP(a_ready_when_empty, !valid_s2, in_ch.ready)
	// a full pipe with a stalled result takes no new beat
	`VCF_ASSERT_IMP(a_no_overrun, valid_s1 && valid_s2 && !out_ch.ready, !in_ch.ready)
	// integer paths never produce inf or nan
	`VCF_ASSERT_IMP(a_finite, valid_s2 && ctype_q != vcf_pkg::CT_FLOAT,
		float_bits_s2[30:23] != 8'hff)
endmodule
